// ===== rtl/packet_sequence_loss_tracker_top_defines.svh =====
// assertion macros for the packet sequence loss tracker
// included by modules that carry concurrent checks, no other dependencies
`ifndef PACKET_SEQUENCE_LOSS_TRACKER_TOP_DEFINES_SVH
`define PACKET_SEQUENCE_LOSS_TRACKER_TOP_DEFINES_SVH

// same-cycle implication, checks disabled while reset is low
`define PSLT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pslt same-cycle check failed");

// next-cycle implication, checks disabled while reset is low
`define PSLT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pslt next-cycle check failed");

`endif

// ===== rtl/pslt_pkg.sv =====
// types and constants shared by the packet sequence loss tracker
// no dependencies
`timescale 1ns / 1ps

package pslt_pkg;

    localparam int SEQ_W = 32;

    localparam logic [SEQ_W-1:0] WINDOW_RESET = 32'd1000;

    typedef logic [SEQ_W-1:0] t_seq;

    typedef enum logic [1:0] {
        STATUS_OK         = 2'd0,
        STATUS_REORDERED  = 2'd1,
        STATUS_DUPLICATE  = 2'd2
    } t_status;

endpackage

// ===== rtl/pslt_seq_if.sv =====
// input channel: one packet sequence number per item
// depends on pslt_pkg
`timescale 1ns / 1ps

interface pslt_seq_if;
    logic              valid;
    logic              ready;
    pslt_pkg::t_seq    seq_number;

    modport source (output valid, output seq_number, input ready);
    modport sink   (input valid, input seq_number, output ready);
endinterface

// ===== rtl/pslt_res_if.sv =====
// result channel: status and running statistics after each item
// depends on pslt_pkg
`timescale 1ns / 1ps

interface pslt_res_if;
    logic                valid;
    logic                ready;
    pslt_pkg::t_status   status;
    pslt_pkg::t_seq      received_count;
    pslt_pkg::t_seq      lost_count;
    pslt_pkg::t_seq      reordered_count;
    pslt_pkg::t_seq      next_expected;
    pslt_pkg::t_seq      highest_seq;

    modport source (
        output valid, output status, output received_count, output lost_count,
        output reordered_count, output next_expected, output highest_seq,
        input ready
    );
    modport sink (
        input valid, input status, input received_count, input lost_count,
        input reordered_count, input next_expected, input highest_seq,
        output ready
    );
endinterface

// ===== rtl/packet_sequence_loss_tracker_top.sv =====
// packet sequence loss tracker: classifies each sequence number and keeps stats
// depends on pslt_pkg, pslt_seq_if, pslt_res_if, packet_sequence_loss_tracker_top_defines.svh
//
//  channel  | dir | handshake          | payload
//  ---------+-----+--------------------+------------------------------------------
//  i_in     | in  | valid/ready        | seq_number
//  o_res    | out | valid/ready        | status, received/lost/reordered counts,
//           |     |                    | next_expected, highest_seq
//  cfg      | in  | i_cfg_we           | i_cfg_wdata -> reorder window
//
// result path from the input accept: the input register, then the statistics registers
// that double as the result register
// one item per cycle unless o_res stalls; the compare/add path between the registers sets it
// i_rst_n clears all counters and sets the window to 1000
// a stalled result holds the input register, which holds i_in.ready low once full
`timescale 1ns / 1ps
`include "packet_sequence_loss_tracker_top_defines.svh"

module packet_sequence_loss_tracker_top (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  pslt_pkg::t_seq         i_cfg_wdata,
    pslt_seq_if.sink               i_in,
    pslt_res_if.source             o_res
);
    import pslt_pkg::*;

    t_seq    r_window;
    logic    r_in_valid;
    t_seq    r_in_seq;
    logic    r_out_valid;
    t_status r_status;
    t_seq    r_received;
    t_seq    r_expected;
    t_seq    r_max_seen;
    t_seq    r_lost;
    t_seq    r_reordered;

    t_status n_status;
    t_seq    n_received;
    t_seq    n_expected;
    t_seq    n_max_seen;
    t_seq    n_lost;
    t_seq    n_reordered;

    logic    advance;
    t_seq    seq_plus1;
    t_seq    floor_seq;

    // the stats registers are the result register, so an item moves on only once
    // the previous result is gone or leaving
    assign advance    = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_in.ready = !r_in_valid || advance;

    assign seq_plus1 = r_in_seq + t_seq'(1);
    assign floor_seq = r_max_seen - r_window;

    always_comb begin
        n_received  = r_received + t_seq'(1);
        n_expected  = r_expected;
        n_max_seen  = r_max_seen;
        n_lost      = r_lost;
        n_reordered = r_reordered;
        n_status    = STATUS_OK;
        if (n_received == t_seq'(1)) begin
            // first item (or counter wrapped round) restarts tracking
            n_expected = seq_plus1;
            n_max_seen = r_in_seq;
        end else if (r_in_seq == r_expected) begin
            n_expected = seq_plus1;
            if (r_in_seq > r_max_seen) begin
                n_max_seen = r_in_seq;
            end
        end else if (r_in_seq > r_expected) begin
            n_lost     = r_lost + (r_in_seq - r_expected);
            n_expected = seq_plus1;
            n_max_seen = r_in_seq;
        end else if (r_in_seq > floor_seq) begin
            n_status    = STATUS_REORDERED;
            n_reordered = r_reordered + t_seq'(1);
            if (r_lost != '0) begin
                n_lost = r_lost - t_seq'(1);
            end
        end else begin
            n_status = STATUS_DUPLICATE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window    <= WINDOW_RESET;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_received  <= '0;
            r_expected  <= '0;
            r_max_seen  <= '0;
            r_lost      <= '0;
            r_reordered <= '0;
        end else begin
            if (i_cfg_we) begin
                r_window <= i_cfg_wdata;
            end
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_received  <= n_received;
                r_expected  <= n_expected;
                r_max_seen  <= n_max_seen;
                r_lost      <= n_lost;
                r_reordered <= n_reordered;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_seq <= i_in.seq_number;
        end
        if (advance) begin
            r_status <= n_status;
        end
    end

    assign o_res.valid           = r_out_valid;
    assign o_res.status          = r_status;
    assign o_res.received_count  = r_received;
    assign o_res.lost_count      = r_lost;
    assign o_res.reordered_count = r_reordered;
    assign o_res.next_expected   = r_expected;
    assign o_res.highest_seq     = r_max_seen;

    `PSLT_ASSERT_NEXT(a_recv_step, i_clk, i_rst_n, advance,
        r_received == $past(r_received) + t_seq'(1))
    `PSLT_ASSERT_NEXT(a_reord_only, i_clk, i_rst_n, advance && (n_status != STATUS_REORDERED),
        $stable(r_reordered))
    `PSLT_ASSERT_NOW(a_hold_means_stall, i_clk, i_rst_n, r_in_valid && !advance,
        r_out_valid && !o_res.ready)
    `PSLT_ASSERT_NOW(a_status_code, i_clk, i_rst_n, r_out_valid,
        (r_status == STATUS_OK) || (r_status == STATUS_REORDERED) ||
        (r_status == STATUS_DUPLICATE))

endmodule

// ===== tb/sv/testbench.sv =====
// self-checking bench for packet_sequence_loss_tracker_top: directed rows, then random phases
// depends on pslt_pkg, pslt_seq_if, pslt_res_if and the tracker rtl
`timescale 1ns / 1ps

module testbench;
    import pslt_pkg::*;

    localparam int CLK_PERIOD     = 10;
    localparam int PIPE_LATENCY   = 2;
    localparam int LONG_HOLD      = 40;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int NUM_PHASES     = 6;
    localparam int PHASE_ITEMS    = 63;
    localparam int NUM_ROWS       = 22;

    typedef struct packed {
        t_status status;
        t_seq    received;
        t_seq    lost;
        t_seq    reordered;
        t_seq    next_exp;
        t_seq    highest;
    } t_stats;

    typedef enum logic {
        ROW_SEQ,
        ROW_WINDOW
    } t_row_kind;

    typedef struct {
        t_row_kind kind;
        t_seq      value;
        bit        typed;
        t_stats    want;
    } t_row;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    t_seq cfg_wdata;

    pslt_seq_if seq_ch ();
    pslt_res_if res_ch ();

    packet_sequence_loss_tracker_top uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in        (seq_ch.sink),
        .o_res       (res_ch.source)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // tracker state as it stands after every accepted item
    t_seq trk_window;
    t_seq trk_received;
    t_seq trk_expected;
    t_seq trk_highest;
    t_seq trk_lost;
    t_seq trk_reordered;

    t_stats pending_stats[$];
    t_row   dir_rows [NUM_ROWS];

    int  fail_count      = 0;
    int  results_checked = 0;
    int  packets_sent    = 0;
    int  windows_used    = 0;
    int  status_seen [3] = '{0, 0, 0};
    int  idle_cycles     = 0;
    int  stall_left      = 0;
    bit  gaps_on         = 1'b1;
    bit  long_hold_asked = 1'b0;
    bit  long_hold_taken = 1'b0;

    function automatic t_stats classify_packet(input t_seq seq);
        t_status st;
        trk_received = trk_received + 32'd1;
        if (trk_received == 32'd1) begin
            trk_expected = seq + 32'd1;
            trk_highest  = seq;
            st = STATUS_OK;
        end else if (seq == trk_expected) begin
            trk_expected = seq + 32'd1;
            if (seq > trk_highest) begin
                trk_highest = seq;
            end
            st = STATUS_OK;
        end else if (seq > trk_expected) begin
            trk_lost     = trk_lost + (seq - trk_expected);
            trk_expected = seq + 32'd1;
            trk_highest  = seq;
            st = STATUS_OK;
        end else if (seq > t_seq'(trk_highest - trk_window)) begin
            trk_reordered = trk_reordered + 32'd1;
            if (trk_lost != 32'd0) begin
                trk_lost = trk_lost - 32'd1;
            end
            st = STATUS_REORDERED;
        end else begin
            st = STATUS_DUPLICATE;
        end
        status_seen[st]++;
        return '{st, trk_received, trk_lost, trk_reordered, trk_expected, trk_highest};
    endfunction

    // mostly well-formed traffic around the tracker's current position
    function automatic t_seq pick_seq();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
            return trk_expected;
        end else if (pick < 60) begin
            return trk_expected + t_seq'($urandom_range(1, 6));
        end else if (pick < 75) begin
            return trk_highest - t_seq'($urandom_range(1, 24));
        end else if (pick < 83) begin
            // one below, on and one above the window floor
            return trk_highest - trk_window + t_seq'($urandom_range(0, 2)) - 32'd1;
        end else if (pick < 92) begin
            return t_seq'($urandom);
        end else begin
            return 32'hFFFF_FFFF - t_seq'($urandom_range(0, 2));
        end
    endfunction

    task automatic check_field(input string name, input t_seq want, input t_seq got);
        if (want !== got) begin
            $error("%s: expected 0x%08h, got 0x%08h", name, want, got);
            fail_count++;
        end
    endtask

    task automatic compare_result();
        t_stats want;
        if (pending_stats.size() == 0) begin
            $error("result with no packet pending: status %0d", res_ch.status);
            fail_count++;
        end else begin
            want = pending_stats.pop_front();
            check_field("status", t_seq'(want.status), t_seq'(res_ch.status));
            check_field("received_count", want.received, res_ch.received_count);
            check_field("lost_count", want.lost, res_ch.lost_count);
            check_field("reordered_count", want.reordered, res_ch.reordered_count);
            check_field("next_expected", want.next_exp, res_ch.next_expected);
            check_field("highest_seq", want.highest, res_ch.highest_seq);
            results_checked++;
        end
    endtask

    // called just after a rising edge; returns at the edge where the item is taken
    task automatic push_seq(input t_seq seq, input bit typed, input t_stats want);
        t_stats got;
        seq_ch.valid      <= 1'b1;
        seq_ch.seq_number <= seq;
        @(posedge clk);
        while (!seq_ch.ready) begin
            @(posedge clk);
        end
        got = classify_packet(seq);
        pending_stats.push_back(typed ? want : got);
        packets_sent++;
    endtask

    task automatic maybe_gap();
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            seq_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        seq_ch.valid <= 1'b0;
        while (pending_stats.size() != 0) begin
            @(posedge clk);
        end
        repeat (PIPE_LATENCY + 2) @(posedge clk);
    endtask

    task automatic write_window(input t_seq w);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= w;
        @(posedge clk);
        cfg_we     <= 1'b0;
        trk_window = w;
        windows_used++;
    endtask

    always @(posedge clk) begin
        if (res_ch.valid && res_ch.ready) begin
            compare_result();
        end
        if (!rst_n) begin
            res_ch.ready <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left--;
            res_ch.ready <= 1'b0;
        end else if (long_hold_asked && !long_hold_taken) begin
            // long stall so the pipeline fills and backs up the input
            long_hold_taken = 1'b1;
            stall_left = LONG_HOLD - 1;
            res_ch.ready <= 1'b0;
        end else if (gaps_on && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(0, 2);
            res_ch.ready <= 1'b0;
        end else begin
            res_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (seq_ch.valid && seq_ch.ready) || (res_ch.valid && res_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
                     idle_cycles, pending_stats.size());
            $display("RESULT: ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        t_seq w;
        rst_n             <= 1'b0;
        cfg_we            <= 1'b0;
        cfg_wdata         <= '0;
        seq_ch.valid      <= 1'b0;
        seq_ch.seq_number <= '0;

        trk_window    = WINDOW_RESET;
        trk_received  = '0;
        trk_expected  = '0;
        trk_highest   = '0;
        trk_lost      = '0;
        trk_reordered = '0;

        dir_rows = '{
            // first item, late packets against the reset window with nothing lost, then a gap and a late fill
            '{ROW_SEQ, 32'd5000, 1'b1,
              '{STATUS_OK, 32'd1, 32'd0, 32'd0, 32'd5001, 32'd5000}},
            '{ROW_SEQ, 32'd4990, 1'b1,
              '{STATUS_REORDERED, 32'd2, 32'd0, 32'd1, 32'd5001, 32'd5000}},
            '{ROW_SEQ, 32'd3000, 1'b1,
              '{STATUS_DUPLICATE, 32'd3, 32'd0, 32'd1, 32'd5001, 32'd5000}},
            '{ROW_SEQ, 32'd4000, 1'b1,
              '{STATUS_DUPLICATE, 32'd4, 32'd0, 32'd1, 32'd5001, 32'd5000}},
            '{ROW_SEQ, 32'd4001, 1'b1,
              '{STATUS_REORDERED, 32'd5, 32'd0, 32'd2, 32'd5001, 32'd5000}},
            '{ROW_SEQ, 32'd5001, 1'b1,
              '{STATUS_OK, 32'd6, 32'd0, 32'd2, 32'd5002, 32'd5001}},
            '{ROW_SEQ, 32'd5010, 1'b1,
              '{STATUS_OK, 32'd7, 32'd8, 32'd2, 32'd5011, 32'd5010}},
            '{ROW_SEQ, 32'd5005, 1'b0, '0},
            // jump to the top: expected number wraps to zero
            '{ROW_SEQ, 32'hFFFF_FFFF, 1'b0, '0},
            '{ROW_SEQ, 32'd0, 1'b0, '0},
            '{ROW_SEQ, 32'd3, 1'b0, '0},
            // window larger than highest, floor wraps high
            '{ROW_SEQ, 32'd2, 1'b0, '0},
            '{ROW_WINDOW, 32'd0, 1'b0, '0},
            '{ROW_SEQ, 32'd4, 1'b0, '0},
            '{ROW_SEQ, 32'd3, 1'b0, '0},
            '{ROW_WINDOW, 32'hFFFF_FFFF, 1'b0, '0},
            // lost count wraps here
            '{ROW_SEQ, 32'hFFFF_FFFF, 1'b0, '0},
            '{ROW_SEQ, 32'd0, 1'b0, '0},
            '{ROW_SEQ, 32'd1, 1'b0, '0},
            '{ROW_SEQ, 32'd2, 1'b0, '0},
            '{ROW_SEQ, 32'd1, 1'b0, '0},
            '{ROW_SEQ, 32'd0, 1'b0, '0}
        };

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_WINDOW) begin
                write_window(dir_rows[i].value);
            end else begin
                maybe_gap();
                push_seq(dir_rows[i].value, dir_rows[i].typed, dir_rows[i].want);
            end
        end

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase)
                0:       w = WINDOW_RESET;
                1:       w = 32'd16;
                2:       w = t_seq'($urandom_range(1, 300));
                3:       w = 32'd0;
                4:       w = t_seq'($urandom);
                default: w = 32'd64;
            endcase
            write_window(w);
            gaps_on = (phase != 2) && (phase != NUM_PHASES - 1);
            if (phase == 1) begin
                long_hold_asked = 1'b1;
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                maybe_gap();
                push_seq(pick_seq(), 1'b0, '0);
            end
        end

        wait_drained();

        $display("covered %0d packets, %0d results checked over %0d window settings",
                 packets_sent, results_checked, windows_used);
        $display("status mix: %0d new or in order, %0d late, %0d duplicate",
                 status_seen[STATUS_OK], status_seen[STATUS_REORDERED],
                 status_seen[STATUS_DUPLICATE]);
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/pslt_pkg.sv
rtl/pslt_seq_if.sv
rtl/pslt_res_if.sv
rtl/packet_sequence_loss_tracker_top.sv
tb/sv/testbench.sv
